@@ src/bpq_pkg.sv @@
// Shared types and codes for the bounded priority queue.
package bpq_pkg;

  localparam int FIELD_W = 16;

  // Command codes carried in req.cmd
  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_REMOVE_MIN = 2'd1;
  localparam logic [1:0] CMD_REMOVE_MAX = 2'd2;

  // Status codes carried in rsp.status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [FIELD_W-1:0]  in_data;
    logic signed [FIELD_W-1:0]  in_priority;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [FIELD_W-1:0]  out_data;
    logic signed [FIELD_W-1:0]  out_priority;
  } rsp_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  // Source of the pending result
  typedef enum logic [2:0] {
    RES_ECHO_OK,
    RES_ECHO_FULL,
    RES_EMPTY,
    RES_NULL,
    RES_BEST
  } res_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     ins_write;
    logic     res_load;
    res_sel_t res_sel;
    logic     scan_start;
    logic     scan_step;
    logic     shift_step;
    logic     shift_done;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       scan_last;
    logic       shift_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ src/bounded_priority_queue.sv @@
// Top level of the bounded priority queue: sequencer plus datapath.
//
//  channel  direction  handshake             beat
//  req      in         req_valid/req_stall   cmd, in_data, in_priority
//  rsp      out        rsp_valid/rsp_stall   status, out_data, out_priority
//
// One beat in, one beat out. Insert, null command, full and empty cases go
// from the load state straight to the result. Remove over n entries whose
// winner sits at position k: a scan over all n entries, then the entries
// behind k moved up, paced by the entry store's one read and one write per
// cycle (one compare per cycle, then one entry moved per cycle). The sequencer
// turns idle, ready for the next beat, as the result turns valid.
// Reset clears the entry count, the sequencer and rsp_valid; the store keeps its contents.
// A new request is taken only when the sequencer is idle, which may happen
// while the previous result still waits in the output register under stall.
module bounded_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 16,
  parameter int PRIO_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  bpq_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output bpq_pkg::rsp_beat_t rsp
);

  bpq_pkg::ctl_cmd_t ctl;
  bpq_pkg::dp_stat_t stat;

  // sequencer: decodes the latched command and steps the passes
  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (ctl)
  );

  // datapath: store, comparator, counters, result and output registers
  bpq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (ctl),
    .stat      (stat)
  );

  // never write past capacity
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_write |-> !stat.full)
    else $error("insert written while full");

  // a pending result is never overwritten while the consumer stalls
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(rsp_valid && rsp_stall))
    else $error("output register overwritten under stall");

  // one request at a time: after acceptance the input side is held off
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted while busy");

  // empty removes return zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == bpq_pkg::STAT_EMPTY) |->
      (rsp.out_data == '0 && rsp.out_priority == '0))
    else $error("empty result carries nonzero payload");

endmodule

@@ src/bpq_ctrl.sv @@
// Sequencer for insert, scan and gap-closing passes.
module bpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bpq_pkg::dp_stat_t stat,
  output bpq_pkg::ctl_cmd_t cmd
);

  bpq_pkg::state_t state;
  bpq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bpq_pkg::S_IDLE: begin
        if (req_valid) state_next = bpq_pkg::S_LOAD;
      end
      bpq_pkg::S_LOAD: begin
        if ((stat.cmd == bpq_pkg::CMD_REMOVE_MIN || stat.cmd == bpq_pkg::CMD_REMOVE_MAX)
            && !stat.empty) begin
          state_next = bpq_pkg::S_SCAN;
        end else begin
          state_next = bpq_pkg::S_RESULT;
        end
      end
      bpq_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = bpq_pkg::S_SHIFT;
      end
      bpq_pkg::S_SHIFT: begin
        if (stat.shift_last) state_next = bpq_pkg::S_RESULT;
      end
      bpq_pkg::S_RESULT: begin
        if (!stat.out_busy) state_next = bpq_pkg::S_IDLE;
      end
      default: state_next = bpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.res_sel = bpq_pkg::RES_NULL;
    req_stall = (state != bpq_pkg::S_IDLE);
    unique case (state)
      bpq_pkg::S_IDLE: begin
        cmd.latch_in = req_valid;
      end
      bpq_pkg::S_LOAD: begin
        unique case (stat.cmd)
          bpq_pkg::CMD_INSERT: begin
            cmd.res_load = 1'b1;
            if (stat.full) begin
              cmd.res_sel = bpq_pkg::RES_ECHO_FULL;
            end else begin
              cmd.ins_write = 1'b1;
              cmd.res_sel   = bpq_pkg::RES_ECHO_OK;
            end
          end
          bpq_pkg::CMD_REMOVE_MIN, bpq_pkg::CMD_REMOVE_MAX: begin
            if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = bpq_pkg::RES_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = bpq_pkg::RES_NULL;
          end
        endcase
      end
      bpq_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      bpq_pkg::S_SHIFT: begin
        if (stat.shift_last) begin
          cmd.shift_done = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = bpq_pkg::RES_BEST;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      bpq_pkg::S_RESULT: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/bpq_dp.sv @@
// Entry store, scan comparator, count and output register.
module bpq_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 16,
  parameter int PRIO_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bpq_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output bpq_pkg::rsp_beat_t rsp,
  input  bpq_pkg::ctl_cmd_t  cmd,
  output bpq_pkg::dp_stat_t  stat
);

  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int MEM_DEPTH = 1 << AW;
  localparam int EW        = DATA_WIDTH + PRIO_WIDTH;

  logic [EW-1:0] mem [MEM_DEPTH];
  logic [EW-1:0] rdata;
  logic [AW-1:0] raddr;

  logic [1:0]                        cmd_q;
  logic signed [bpq_pkg::FIELD_W-1:0] data_q;
  logic signed [bpq_pkg::FIELD_W-1:0] prio_q;

  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] wp;
  logic [AW-1:0] best_idx;
  logic signed [DATA_WIDTH-1:0] best_d;
  logic signed [PRIO_WIDTH-1:0] best_p;

  bpq_pkg::rsp_beat_t res;

  logic signed [DATA_WIDTH-1:0] rd_d;
  logic signed [PRIO_WIDTH-1:0] rd_p;
  logic signed [DATA_WIDTH-1:0] wr_d;
  logic signed [PRIO_WIDTH-1:0] wr_p;
  logic                         better;
  logic [AW-1:0]                sel_idx;
  logic                         scan_last;
  logic                         shift_last;

  assign rd_d = rdata[EW-1:PRIO_WIDTH];
  assign rd_p = rdata[PRIO_WIDTH-1:0];
  // sign-extend or truncate the 16-bit fields into storage width
  assign wr_d = DATA_WIDTH'(data_q);
  assign wr_p = PRIO_WIDTH'(prio_q);

  assign scan_last  = (CW'(pos) == count - CW'(1));
  assign shift_last = (CW'(wp) == count - CW'(1));

  // first entry always wins; ties keep the older one
  always_comb begin
    if (pos == '0) begin
      better = 1'b1;
    end else if (cmd_q == bpq_pkg::CMD_REMOVE_MAX) begin
      better = (rd_p > best_p);
    end else begin
      better = (rd_p < best_p);
    end
  end

  assign sel_idx = better ? pos : best_idx;

  always_comb begin
    priority if (cmd.scan_step && scan_last) begin
      raddr = AW'({1'b0, sel_idx} + (AW+1)'(1));
    end else if (cmd.scan_step) begin
      raddr = AW'({1'b0, pos} + (AW+1)'(1));
    end else if (cmd.shift_step) begin
      raddr = AW'({1'b0, wp} + (AW+1)'(2));
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.ins_write) begin
      mem[count[AW-1:0]] <= {wr_d, wr_p};
    end else if (cmd.shift_step) begin
      mem[wp] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_q  <= req.cmd;
      data_q <= req.in_data;
      prio_q <= req.in_priority;
    end
    if (cmd.scan_start) begin
      pos <= '0;
    end else if (cmd.scan_step && !scan_last) begin
      pos <= pos + AW'(1);
    end
    if (cmd.scan_step && better) begin
      best_idx <= pos;
      best_d   <= rd_d;
      best_p   <= rd_p;
    end
    if (cmd.scan_step && scan_last) begin
      wp <= sel_idx;
    end else if (cmd.shift_step) begin
      wp <= wp + AW'(1);
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        bpq_pkg::RES_ECHO_OK:   res <= {bpq_pkg::STAT_OK, data_q, prio_q};
        bpq_pkg::RES_ECHO_FULL: res <= {bpq_pkg::STAT_FULL, data_q, prio_q};
        bpq_pkg::RES_EMPTY:     res <= {bpq_pkg::STAT_EMPTY, 32'd0};
        bpq_pkg::RES_BEST: begin
          res <= {bpq_pkg::STAT_OK, bpq_pkg::FIELD_W'(best_d),
                  bpq_pkg::FIELD_W'(best_p)};
        end
        default:                res <= {bpq_pkg::STAT_OK, 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_write) begin
      count <= count + CW'(1);
    end else if (cmd.shift_done) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) rsp <= res;
  end

  assign stat.cmd        = cmd_q;
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.empty      = (count == '0);
  assign stat.scan_last  = scan_last;
  assign stat.shift_last = shift_last;
  assign stat.out_busy   = rsp_valid && rsp_stall;

endmodule

@@ dv/bpq_checker.sv @@
// Response checker for the bounded priority queue: predicts each response and compares it.
`timescale 1ns / 1ps

module bpq_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  bpq_pkg::req_beat_t req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  bpq_pkg::rsp_beat_t rsp,
  output int                 fail_count,
  output int                 outstanding
);

  // Shadow copy of the queue, oldest entry at index 0
  logic signed [bpq_pkg::FIELD_W-1:0] pq_data [DEPTH];
  logic signed [bpq_pkg::FIELD_W-1:0] pq_prio [DEPTH];
  int                                 pq_count;

  bpq_pkg::rsp_beat_t due_rsp[$];
  bpq_pkg::rsp_beat_t want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    pq_count    = 0;
  end

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 100) $display("checker: %0t %s", $realtime, msg);
  endtask

  // Applies one request beat to the shadow queue and returns its response
  function automatic bpq_pkg::rsp_beat_t pq_respond(bpq_pkg::req_beat_t r);
    bpq_pkg::rsp_beat_t o;
    int                 pick;
    o = '0;
    if (r.cmd == bpq_pkg::CMD_INSERT) begin
      o.out_data     = r.in_data;
      o.out_priority = r.in_priority;
      if (pq_count >= DEPTH) begin
        o.status = bpq_pkg::STAT_FULL;
      end else begin
        pq_data[pq_count] = r.in_data;
        pq_prio[pq_count] = r.in_priority;
        pq_count++;
      end
    end else if (r.cmd == bpq_pkg::CMD_REMOVE_MIN || r.cmd == bpq_pkg::CMD_REMOVE_MAX) begin
      if (pq_count == 0) begin
        o.status = bpq_pkg::STAT_EMPTY;
      end else begin
        // strict compare keeps the oldest of equal priorities
        pick = 0;
        for (int i = 1; i < pq_count; i++) begin
          if (r.cmd == bpq_pkg::CMD_REMOVE_MIN ? pq_prio[i] < pq_prio[pick]
                                               : pq_prio[i] > pq_prio[pick]) pick = i;
        end
        o.status       = bpq_pkg::STAT_OK;
        o.out_data     = pq_data[pick];
        o.out_priority = pq_prio[pick];
        for (int i = pick; i + 1 < pq_count; i++) begin
          pq_data[i] = pq_data[i+1];
          pq_prio[i] = pq_prio[i+1];
        end
        pq_count--;
      end
    end
    // any other selector: no change, all-zero response
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pq_count = 0;
      due_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          report_mismatch($sformatf("response beat with nothing outstanding: %h", rsp));
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %h, expected %h", rsp.status, want.status));
          if (rsp.out_data !== want.out_data)
            report_mismatch($sformatf("out_data %h, expected %h",
                                      rsp.out_data, want.out_data));
          if (rsp.out_priority !== want.out_priority)
            report_mismatch($sformatf("out_priority %h, expected %h",
                                      rsp.out_priority, want.out_priority));
        end
      end
      if (req_valid && !req_stall) due_rsp.push_back(pq_respond(req));
    end
    outstanding = due_rsp.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the bounded priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH = 16;
  // Selector value with no defined operation; the block must answer it with zeros
  localparam logic [1:0] CMD_NULL = 2'd3;
  // Watchdog. Slowest legal beat is a full remove plus the longest send gap
  // plus the longest response stall; ~1900 beats land well under this.
  localparam int CYCLE_LIMIT = 1000000;
  // Long receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 300;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  bpq_pkg::req_beat_t req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  bpq_pkg::rsp_beat_t rsp;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // Idle densities in percent per beat / per cycle; zero means no idling
  int tx_pct = 0;
  int rx_pct = 0;
  int rx_left = 0;
  logic hold_go = 1'b0;
  logic long_hold = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bounded_priority_queue #(
    .DEPTH     (QUEUE_DEPTH),
    .DATA_WIDTH(bpq_pkg::FIELD_W),
    .PRIO_WIDTH(bpq_pkg::FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  bpq_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (mismatches),
    .outstanding(outstanding)
  );

  // Watchdog: a lost or stuck beat ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall bursts of random length, plus the long hold-off.
  // Driven at the falling edge so the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    if (rx_left > 0) begin
      rx_left--;
    end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
      rx_left = $urandom_range(1, 18);
    end
    rsp_stall <= long_hold || (rx_left > 0);
  end

  // Long hold-off, counted at the rising edge so the receiver reads a stable flag
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // Offer one beat and hold it steady until the block takes it
  task automatic send_req(logic [1:0] cmd, logic signed [bpq_pkg::FIELD_W-1:0] d,
                          logic signed [bpq_pkg::FIELD_W-1:0] p);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= '{cmd: cmd, in_data: d, in_priority: p};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Sender gap: occasionally drop valid for a burst of random length
  task automatic tx_gap();
    int n;
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      n = $urandom_range(1, 18);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random beats with a command mix that steers the queue toward full, empty
  // or neither; a narrow priority span piles up ties.
  task automatic run_phase(int n, mix_t mix, bit narrow);
    int                                 r;
    int                                 sel;
    logic [1:0]                         cmd;
    logic signed [bpq_pkg::FIELD_W-1:0] d;
    logic signed [bpq_pkg::FIELD_W-1:0] p;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: begin
          cmd = r < 75 ? bpq_pkg::CMD_INSERT : r < 87 ? bpq_pkg::CMD_REMOVE_MIN :
                r < 99 ? bpq_pkg::CMD_REMOVE_MAX : CMD_NULL;
        end
        MIX_DRAIN: begin
          cmd = r < 25 ? bpq_pkg::CMD_INSERT : r < 62 ? bpq_pkg::CMD_REMOVE_MIN :
                r < 99 ? bpq_pkg::CMD_REMOVE_MAX : CMD_NULL;
        end
        default: begin
          cmd = r < 49 ? bpq_pkg::CMD_INSERT : r < 74 ? bpq_pkg::CMD_REMOVE_MIN :
                r < 99 ? bpq_pkg::CMD_REMOVE_MAX : CMD_NULL;
        end
      endcase
      d   = bpq_pkg::FIELD_W'($urandom);
      sel = $urandom_range(0, 19);
      if (sel == 0)      p = 16'sh8000;
      else if (sel == 1) p = 16'sh7FFF;
      else if (narrow)   p = bpq_pkg::FIELD_W'($urandom_range(0, 6) - 3);
      else               p = bpq_pkg::FIELD_W'($urandom);
      tx_gap();
      send_req(cmd, d, p);
    end
  endtask

  initial begin
    logic signed [bpq_pkg::FIELD_W-1:0] d;
    logic signed [bpq_pkg::FIELD_W-1:0] p;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty removes and the null selector on an empty queue
    send_req(bpq_pkg::CMD_REMOVE_MIN, 16'sh7FFF, 16'sh7FFF);
    send_req(bpq_pkg::CMD_REMOVE_MAX, -16'sd1, 16'sh8000);
    send_req(CMD_NULL, 16'sh5555, 16'shAAAA);

    // Fill to capacity with extreme values and duplicated extreme priorities
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       begin d = 16'sh7FFF; p = 16'sh8000; end
        1:       begin d = 16'sh8000; p = 16'sh7FFF; end
        2:       begin d = 16'sh0000; p = 16'sh0000; end
        3:       begin d = -16'sd1;   p = -16'sd1;   end
        4:       begin d = 16'sh5555; p = 16'sh8000; end  // ties entry 0 on minimum
        5:       begin d = 16'shAAAA; p = 16'sh7FFF; end  // ties entry 1 on maximum
        default: begin
          d = bpq_pkg::FIELD_W'($urandom);
          p = bpq_pkg::FIELD_W'($urandom_range(0, 200) - 100);
        end
      endcase
      send_req(bpq_pkg::CMD_INSERT, d, p);
    end

    // Insert into a full queue, then removes that resolve ties, then null on a busy queue
    send_req(bpq_pkg::CMD_INSERT, 16'sh8000, 16'sh7FFF);
    send_req(bpq_pkg::CMD_REMOVE_MIN, 16'sh0000, 16'sh0000);
    send_req(bpq_pkg::CMD_REMOVE_MIN, 16'sh0000, 16'sh0000);
    send_req(bpq_pkg::CMD_REMOVE_MAX, 16'sh0000, 16'sh0000);
    send_req(bpq_pkg::CMD_REMOVE_MAX, 16'sh0000, 16'sh0000);
    send_req(CMD_NULL, -16'sd1, -16'sd1);

    // Random phases; every fourth runs without idling on either side
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 4 == 0) begin
        tx_pct = 0;
        rx_pct = 0;
      end else begin
        tx_pct = $urandom_range(5, 30);
        rx_pct = $urandom_range(2, 12);
      end
      // fill phase: the receiver backs off while the sender keeps offering beats
      if (ph == 3) hold_go = 1'b1;
      run_phase(140, mix_t'(ph % 3), ph[0]);
    end

    // Closing stretch with no idling
    tx_pct = 0;
    rx_pct = 0;
    run_phase(200, MIX_EVEN, 1'b0);
    @(negedge clk);
    req_valid <= 1'b0;

    // Drain: the watchdog covers a response that never shows up
    do @(negedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/bpq_pkg.sv
src/bpq_ctrl.sv
src/bpq_dp.sv
src/bounded_priority_queue.sv
dv/bpq_checker.sv
dv/tb.sv
